/* rtl/core/iaf_pkg.sv */
// ----------------------------------------------------------------------------
// Integer to ASCII formatter package
// Shared request, response and format types, operation codes and ASCII
// constants for the formatter blocks.
// ----------------------------------------------------------------------------
package iaf_pkg;

    // Default parameter values.
    localparam int DEF_MAX_WIDTH  = 63;
    localparam int DEF_VALUE_BITS = 64;

    // Fixed field widths.
    localparam int OP_W    = 3;
    localparam int VALUE_W = 64;
    localparam int WIDTH_W = 6;
    localparam int SM_W    = 2;
    localparam int CH_W    = 8;

    // Conversion kinds.
    localparam logic [OP_W-1:0] OP_UDEC = 3'd0;
    localparam logic [OP_W-1:0] OP_SDEC = 3'd1;
    localparam logic [OP_W-1:0] OP_HEXL = 3'd2;
    localparam logic [OP_W-1:0] OP_HEXU = 3'd3;
    localparam logic [OP_W-1:0] OP_OCT  = 3'd4;
    localparam logic [OP_W-1:0] OP_CHAR = 3'd5;

    // Forced sign modes for positive signed values.
    localparam logic [SM_W-1:0] SM_NONE  = 2'd0;
    localparam logic [SM_W-1:0] SM_PLUS  = 2'd1;
    localparam logic [SM_W-1:0] SM_SPACE = 2'd2;

    // ASCII characters.
    localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CH_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CH_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CH_W-1:0] CH_SPACE   = 8'h20;

    // One conversion request.
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic               wide;
        logic [VALUE_W-1:0] value;
        logic [WIDTH_W-1:0] width;
        logic               left_justify;
        logic               zero_pad;
        logic [SM_W-1:0]    sign_mode;
    } t_req;

    // One output character.
    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            last;
    } t_rsp;

    // Field layout handed from the digit generator to the emitter.
    typedef struct packed {
        logic               left_justify;
        logic               zero_pad;
        logic [WIDTH_W-1:0] width;
        logic               has_sign;
        logic [CH_W-1:0]    sign_ch;
        logic               upper;
        logic               is_char;
        logic [CH_W-1:0]    char_ch;
    } t_fmt;

endpackage

/* rtl/core/iaf_digit_gen.sv */
// ----------------------------------------------------------------------------
// Digit generator
// Takes a request, builds its digits (double dabble for decimal, one bit per
// cycle, a direct load for hex and octal), trims leading zeros one digit per
// cycle and holds them for the emitter to read out; a character skips both.
// ----------------------------------------------------------------------------
module iaf_digit_gen
    import iaf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    localparam int NDIG  = (VALUE_BITS + 2) / 3,
    localparam int IDX_W = $clog2(NDIG),
    localparam int CNT_W = $clog2(NDIG + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  t_req             i_req,
    output logic             o_done,
    output t_fmt             o_fmt,
    output logic [CNT_W-1:0] o_nd,
    input  logic             i_release,
    input  logic [IDX_W-1:0] i_rd_addr,
    output logic [3:0]       o_rd_dig
);

    localparam int BIT_W = $clog2(VALUE_BITS + 1);
    localparam int EXT_W = 4 * NDIG;

    typedef enum logic [1:0] {
        G_IDLE,
        G_DABBLE,
        G_SCAN,
        G_DONE
    } t_gstate;

    t_gstate               r_state, n_state;
    t_fmt                  r_fmt, n_fmt;
    logic [CNT_W-1:0]      r_nd, n_nd;
    logic [IDX_W-1:0]      r_ptr, n_ptr;
    logic [VALUE_BITS-1:0] r_sh, n_sh;
    logic [BIT_W-1:0]      r_bits, n_bits;
    logic [3:0]            r_dig [NDIG];
    logic [3:0]            n_dig [NDIG];

    logic [VALUE_BITS-1:0] w_mask;
    logic [VALUE_BITS-1:0] w_mag;
    logic [VALUE_BITS-1:0] w_abs;
    logic [EXT_W-1:0]      w_ext;
    logic                  w_sbit;
    logic                  w_neg;
    logic                  w_force;
    logic [3:0]            w_adj [NDIG];
    logic [IDX_W-1:0]      w_rd_idx;

    // Operand selection, masking and magnitude of negative values.
    always_comb begin
        w_mask  = i_req.wide ? '1 : VALUE_BITS'(32'hFFFF_FFFF);
        w_mag   = i_req.value[VALUE_BITS-1:0] & w_mask;
        w_sbit  = i_req.wide ? w_mag[VALUE_BITS-1] : w_mag[31];
        w_neg   = (i_req.op == OP_SDEC) && w_sbit;
        w_force = (i_req.op == OP_SDEC) && !w_sbit && (w_mag != '0)
                  && ((i_req.sign_mode == SM_PLUS) || (i_req.sign_mode == SM_SPACE));
        w_abs   = w_neg ? ((VALUE_BITS'(0) - w_mag) & w_mask) : w_mag;
        w_ext   = EXT_W'(w_abs);
    end

    // Single read port: the scan owns it until the digits are handed over.
    assign w_rd_idx = (r_state == G_DONE) ? i_rd_addr : r_ptr;
    assign o_rd_dig = r_dig[w_rd_idx];

    // Add-three correction of every BCD digit before the next shift.
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            w_adj[i] = (r_dig[i] >= 4'd5) ? r_dig[i] + 4'd3 : r_dig[i];
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        n_fmt   = r_fmt;
        n_nd    = r_nd;
        n_ptr   = r_ptr;
        n_sh    = r_sh;
        n_bits  = r_bits;
        for (int i = 0; i < NDIG; i++) begin
            n_dig[i] = r_dig[i];
        end

        case (r_state)
            G_IDLE: begin
                if (i_req_valid && (i_req.op <= OP_CHAR)) begin
                    n_fmt.left_justify = i_req.left_justify;
                    n_fmt.zero_pad     = i_req.zero_pad && (i_req.op != OP_CHAR);
                    n_fmt.width        = (i_req.width > WIDTH_W'(MAX_WIDTH)) ?
                                         WIDTH_W'(MAX_WIDTH) : i_req.width;
                    n_fmt.has_sign     = w_neg || w_force;
                    n_fmt.sign_ch      = w_neg ? CH_MINUS :
                                         (i_req.sign_mode == SM_PLUS) ? CH_PLUS : CH_SPACE;
                    n_fmt.upper        = (i_req.op == OP_HEXU);
                    n_fmt.is_char      = (i_req.op == OP_CHAR);
                    n_fmt.char_ch      = i_req.value[CH_W-1:0];
                    n_ptr              = IDX_W'(NDIG - 1);
                    if (i_req.op == OP_CHAR) begin
                        n_nd    = CNT_W'(1);
                        n_state = G_DONE;
                    end else if ((i_req.op == OP_UDEC) || (i_req.op == OP_SDEC)) begin
                        for (int i = 0; i < NDIG; i++) begin
                            n_dig[i] = '0;
                        end
                        n_sh    = i_req.wide ? w_abs : (w_abs << (VALUE_BITS - 32));
                        n_bits  = i_req.wide ? BIT_W'(VALUE_BITS) : BIT_W'(32);
                        n_state = G_DABBLE;
                    end else begin
                        for (int i = 0; i < NDIG; i++) begin
                            n_dig[i] = (i_req.op == OP_OCT) ? {1'b0, w_ext[3*i +: 3]} :
                                                              w_ext[4*i +: 4];
                        end
                        n_state = G_SCAN;
                    end
                end
            end
            G_DABBLE: begin
                // Shift the next magnitude bit into the corrected BCD chain.
                n_dig[0] = {w_adj[0][2:0], r_sh[VALUE_BITS-1]};
                for (int i = 1; i < NDIG; i++) begin
                    n_dig[i] = {w_adj[i][2:0], w_adj[i-1][3]};
                end
                n_sh   = r_sh << 1;
                n_bits = r_bits - BIT_W'(1);
                if (r_bits == BIT_W'(1)) begin
                    n_state = G_SCAN;
                end
            end
            G_SCAN: begin
                // Step down past leading zeros; at least one digit remains.
                if ((r_ptr != '0) && (o_rd_dig == 4'd0)) begin
                    n_ptr = r_ptr - IDX_W'(1);
                end else begin
                    n_nd    = CNT_W'(r_ptr) + CNT_W'(1);
                    n_state = G_DONE;
                end
            end
            G_DONE: begin
                if (i_release) begin
                    n_state = G_IDLE;
                end
            end
            default: begin
                n_state = G_IDLE;
            end
        endcase
    end

    // State and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_fmt  <= n_fmt;
        r_nd   <= n_nd;
        r_ptr  <= n_ptr;
        r_sh   <= n_sh;
        r_bits <= n_bits;
        for (int i = 0; i < NDIG; i++) begin
            r_dig[i] <= n_dig[i];
        end
    end

    assign o_req_ready = (r_state == G_IDLE);
    assign o_done      = (r_state == G_DONE);
    assign o_fmt       = r_fmt;
    assign o_nd        = r_nd;

endmodule

/* rtl/core/iaf_emitter.sv */
// ----------------------------------------------------------------------------
// Character emitter
// Walks through left pad, sign, zero pad, digits and right pad, one
// character per cycle, into an output register that holds under stall.
// ----------------------------------------------------------------------------
module iaf_emitter
    import iaf_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    localparam int NDIG  = (VALUE_BITS + 2) / 3,
    localparam int IDX_W = $clog2(NDIG),
    localparam int CNT_W = $clog2(NDIG + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_done,
    input  t_fmt             i_fmt,
    input  logic [CNT_W-1:0] i_nd,
    output logic             o_release,
    output logic [IDX_W-1:0] o_rd_addr,
    input  logic [3:0]       i_rd_dig,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output t_rsp             o_rsp
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LPAD,
        PH_SIGN,
        PH_ZPAD,
        PH_DIG,
        PH_RPAD
    } t_phase;

    t_phase             r_phase, n_phase;
    t_fmt               r_fmt, n_fmt;
    logic [CNT_W-1:0]   r_nd, n_nd;
    logic [WIDTH_W-1:0] r_pad, n_pad;
    logic [WIDTH_W-1:0] r_cnt, n_cnt;
    logic [WIDTH_W-1:0] r_rem, n_rem;
    t_rsp               r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic               c_idle;
    t_fmt               c_fmt;
    logic [CNT_W-1:0]   c_nd;
    logic [WIDTH_W-1:0] c_pad;
    logic [WIDTH_W-1:0] w_len;
    logic [WIDTH_W-1:0] w_start_pad;
    logic               w_en_lpad, w_en_zpad, w_en_rpad;
    t_phase             w_next_ph;
    logic [WIDTH_W-1:0] w_load;
    logic [WIDTH_W-1:0] w_cnt_m1;
    logic               w_step;
    logic               w_start;
    logic [CH_W-1:0]    w_dig_ch;
    logic [CH_W-1:0]    w_ch;

    // Phase that follows the current one, skipping empty phases.
    function automatic t_phase next_ph(t_phase cur, logic lp, logic sg, logic zp, logic rp);
        t_phase nx;
        case (cur)
            PH_IDLE: nx = lp ? PH_LPAD : sg ? PH_SIGN : zp ? PH_ZPAD : PH_DIG;
            PH_LPAD: nx = sg ? PH_SIGN : zp ? PH_ZPAD : PH_DIG;
            PH_SIGN: nx = zp ? PH_ZPAD : PH_DIG;
            PH_ZPAD: nx = PH_DIG;
            PH_DIG:  nx = rp ? PH_RPAD : PH_IDLE;
            PH_RPAD: nx = PH_IDLE;
            default: nx = PH_IDLE;
        endcase
        return nx;
    endfunction

    // Field layout of the current or the starting conversion.
    always_comb begin
        c_idle      = (r_phase == PH_IDLE);
        w_len       = WIDTH_W'(i_nd) + WIDTH_W'(i_fmt.has_sign);
        w_start_pad = (i_fmt.width > w_len) ? i_fmt.width - w_len : '0;
        c_fmt       = c_idle ? i_fmt : r_fmt;
        c_nd        = c_idle ? i_nd : r_nd;
        c_pad       = c_idle ? w_start_pad : r_pad;
        w_en_lpad   = !c_fmt.left_justify && !c_fmt.zero_pad && (c_pad != '0);
        w_en_zpad   = !c_fmt.left_justify && c_fmt.zero_pad && (c_pad != '0);
        w_en_rpad   = c_fmt.left_justify && (c_pad != '0);
        w_next_ph   = next_ph(r_phase, w_en_lpad, c_fmt.has_sign, w_en_zpad, w_en_rpad);
        // The sign is a single character; pads run for the pad count.
        w_load      = (w_next_ph == PH_DIG)  ? WIDTH_W'(c_nd) :
                      (w_next_ph == PH_SIGN) ? WIDTH_W'(1) : c_pad;
        w_start     = c_idle && i_done;
        w_step      = !c_idle && (!r_out_valid || i_rsp_ready);
        w_cnt_m1    = r_cnt - WIDTH_W'(1);
    end

    // Digits are stored least significant first; read them top down.
    assign o_rd_addr = w_cnt_m1[IDX_W-1:0];
    assign o_release = w_step && (r_phase == PH_DIG) && (r_cnt == WIDTH_W'(1));

    // Character of the current phase.
    always_comb begin
        if (i_rd_dig < 4'd10) begin
            w_dig_ch = CH_ZERO + CH_W'(i_rd_dig);
        end else begin
            w_dig_ch = (r_fmt.upper ? CH_UPPER_A : CH_LOWER_A) + CH_W'(i_rd_dig)
                       - CH_W'(10);
        end
        case (r_phase)
            PH_SIGN: w_ch = r_fmt.sign_ch;
            PH_ZPAD: w_ch = CH_ZERO;
            PH_DIG:  w_ch = r_fmt.is_char ? r_fmt.char_ch : w_dig_ch;
            default: w_ch = CH_SPACE;
        endcase
    end

    // Next-state logic.
    always_comb begin
        n_phase     = r_phase;
        n_fmt       = r_fmt;
        n_nd        = r_nd;
        n_pad       = r_pad;
        n_cnt       = r_cnt;
        n_rem       = r_rem;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_rsp_ready;

        if (w_start) begin
            n_fmt   = i_fmt;
            n_nd    = i_nd;
            n_pad   = w_start_pad;
            n_rem   = w_start_pad + w_len;
            n_phase = w_next_ph;
            n_cnt   = w_load;
        end else if (w_step) begin
            n_out.ch    = w_ch;
            n_out.last  = (r_rem == WIDTH_W'(1));
            n_out_valid = 1'b1;
            n_rem       = r_rem - WIDTH_W'(1);
            if (r_cnt == WIDTH_W'(1)) begin
                n_phase = w_next_ph;
                n_cnt   = w_load;
            end else begin
                n_cnt = w_cnt_m1;
            end
        end
    end

    // State and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
        r_fmt <= n_fmt;
        r_nd  <= n_nd;
        r_pad <= n_pad;
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_out <= n_out;
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

/* rtl/core/integer_to_ascii_formatter_unit.sv */
// ----------------------------------------------------------------------------
// Integer to ASCII formatter unit
// Formats one printf-style integer or character conversion per request.
// ----------------------------------------------------------------------------
// Usage:
// A request (i_req_valid / o_req_ready, payload i_req) carries the value,
// the conversion kind and the field options. The characters leave on the
// response channel (o_rsp_valid / i_rsp_ready, payload o_rsp), one per
// cycle while the receiver is ready, with last set on the final character.
// Requests with an unused kind are taken and produce nothing.
// Decimal conversions shift the value through a double dabble converter
// one bit per cycle; all numeric kinds then scan down from the top digit
// position until a nonzero digit or the lowest position. The emitter then
// loads the field layout and registers each character into its output
// register. The digit store is the only one, so the next request is taken
// once the last digit has been read out; trailing pad may still be
// draining then.
// A stalled receiver holds the output register and the character walk.
// Reset is synchronous and returns both stages to idle, dropping any work.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_unit
    import iaf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    localparam int NDIG  = (VALUE_BITS + 2) / 3;
    localparam int IDX_W = $clog2(NDIG);
    localparam int CNT_W = $clog2(NDIG + 1);

    logic             w_done;
    t_fmt             w_fmt;
    logic [CNT_W-1:0] w_nd;
    logic             w_release;
    logic [IDX_W-1:0] w_rd_addr;
    logic [3:0]       w_rd_dig;

    // Digit generation and storage.
    iaf_digit_gen #(
        .MAX_WIDTH  (MAX_WIDTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_gen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_done      (w_done),
        .o_fmt       (w_fmt),
        .o_nd        (w_nd),
        .i_release   (w_release),
        .i_rd_addr   (w_rd_addr),
        .o_rd_dig    (w_rd_dig)
    );

    // Field assembly and character output.
    iaf_emitter #(
        .VALUE_BITS (VALUE_BITS)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_done      (w_done),
        .i_fmt       (w_fmt),
        .i_nd        (w_nd),
        .o_release   (w_release),
        .o_rd_addr   (w_rd_addr),
        .i_rd_dig    (w_rd_dig),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

`ifndef SYNTHESIS
    // The emitter only frees the digit store while it holds a finished conversion.
    a_release_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_release |-> w_done)
        else $error("digit store released while no conversion is held");

    // A finished conversion always has at least one digit.
    a_nd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (w_nd != '0))
        else $error("finished conversion with no digits");

    // The character kind never carries a sign.
    a_char_nosign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && w_fmt.is_char) |-> !w_fmt.has_sign)
        else $error("character conversion with a sign");
`endif

endmodule
